[rtl/core/rbfs_pkg.sv]
package rbfs_pkg;

  // Default geometry of the store
  localparam int unsigned WORD_BYTES  = 8;
  localparam int unsigned STORE_BYTES = 16 * 1024;

  // Byte position and file length width; both saturate at the top value
  localparam int unsigned POS_W   = 15;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 4;

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [COUNT_W-1:0]  byte_count_req;
    logic [DATA_W-1:0]   write_word;
  } req_t;

  typedef struct packed {
    cmd_e                resp_kind;
    logic [COUNT_W-1:0]  bytes_done;
    logic [DATA_W-1:0]   read_word;
  } resp_t;

  // Word store port control
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // Response under way while the store read completes
  typedef struct packed {
    cmd_e               kind;
    logic [COUNT_W-1:0] done;
    logic               rd;
  } s1_info_t;

endpackage

[rtl/core/rbfs_ram.sv]
module rbfs_ram #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = 11
) (
  input  logic                     clk_i,
  input  rbfs_pkg::mem_ctl_t       mem_ctl_i,
  input  logic [AddrW-1:0]         addr_i,
  input  logic [rbfs_pkg::DATA_W-1:0] wdata_i,
  output logic [rbfs_pkg::DATA_W-1:0] rdata_o
);
  import rbfs_pkg::*;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (mem_ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/rbfs_ctrl.sv]
module rbfs_ctrl #(
  parameter int unsigned WordBytes  = rbfs_pkg::WORD_BYTES,
  parameter int unsigned StoreBytes = rbfs_pkg::STORE_BYTES,
  parameter int unsigned AddrW      = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rbfs_pkg::req_t              in_req_i,
  output logic                        s1_valid_o,
  input  logic                        s1_take_i,
  output rbfs_pkg::s1_info_t          s1_info_o,
  output rbfs_pkg::mem_ctl_t          mem_ctl_o,
  output logic [AddrW-1:0]            mem_addr_o,
  output logic [rbfs_pkg::DATA_W-1:0] mem_wdata_o
);
  import rbfs_pkg::*;

  localparam int unsigned Depth      = StoreBytes / WordBytes;
  // Word address by reciprocal multiply, exact for every POS_W-bit position
  localparam int unsigned RecipShift = POS_W + 3;
  localparam int unsigned Recip      = ((1 << RecipShift) + WordBytes - 1) / WordBytes;
  localparam int unsigned ProdW      = POS_W + RecipShift + 1;
  localparam logic [DATA_W-1:0] WordMask =
      (WordBytes >= 8) ? '1 : DATA_W'((65'd1 << (8 * WordBytes)) - 65'd1);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] len_q, len_d;
  logic             s1_valid_q, s1_valid_d;
  s1_info_t         s1_info_q, s1_info_d;

  logic             accept;
  logic [ProdW-1:0] prod;
  logic [POS_W:0]   word_addr;
  logic             addr_ok;
  logic [POS_W:0]   pos_sum;
  logic [POS_W-1:0] pos_adv;
  mem_ctl_t         mem_ctl;

  assign in_ready_o = !s1_valid_q || s1_take_i;
  assign accept     = in_valid_i && in_ready_o;

  assign prod      = ProdW'(pos_q) * ProdW'(Recip);
  assign word_addr = {1'b0, prod[RecipShift +: POS_W]};
  assign addr_ok   = 17'(word_addr) < 17'(Depth);

  // Saturating advance
  assign pos_sum = {1'b0, pos_q} + (POS_W + 1)'(in_req_i.byte_count_req);
  assign pos_adv = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];

  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    mem_ctl.we  = 1'b0;
    mem_ctl.re  = 1'b0;
    s1_info_d   = s1_info_q;
    s1_valid_d  = s1_valid_q && !s1_take_i;
    if (accept) begin
      s1_valid_d     = 1'b1;
      s1_info_d.kind = in_req_i.cmd;
      s1_info_d.done = '0;
      s1_info_d.rd   = 1'b0;
      unique case (in_req_i.cmd)
        CMD_OPEN: begin
          pos_d = '0;
        end
        CMD_WRITE: begin
          if (17'(len_q) < 17'(StoreBytes)) begin
            mem_ctl.we     = (in_req_i.byte_count_req != '0) && addr_ok;
            s1_info_d.done = in_req_i.byte_count_req;
            pos_d          = pos_adv;
            len_d          = (pos_adv > len_q) ? pos_adv : len_q;
          end
        end
        CMD_READ: begin
          if (pos_q < len_q) begin
            // Past the last word: report the count, return zero
            mem_ctl.re     = addr_ok;
            s1_info_d.rd   = addr_ok;
            s1_info_d.done = in_req_i.byte_count_req;
            pos_d          = pos_adv;
          end
        end
        CMD_CLOSE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      len_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      len_q      <= len_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_info_q <= s1_info_d;
  end

  assign s1_valid_o  = s1_valid_q;
  assign s1_info_o   = s1_info_q;
  assign mem_ctl_o   = mem_ctl;
  assign mem_addr_o  = word_addr[AddrW-1:0];
  assign mem_wdata_o = in_req_i.write_word & WordMask;

  a_one_port_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl.we && mem_ctl.re))
    else $error("store written and read for one request");

  a_mem_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.we || mem_ctl.re) |-> accept)
    else $error("store access without a transfer");

  a_open_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_req_i.cmd == CMD_OPEN |=> pos_q == '0)
    else $error("open did not rewind the position");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_take_i |=> s1_valid_q && $stable(s1_info_q))
    else $error("stalled response lost or changed");

  a_len_never_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> len_d >= len_q)
    else $error("file length shrank");

endmodule

[rtl/core/ram_backed_file_store.sv]
// One file kept in on-chip word RAM, served by open, write, read and close requests.
// Input channel: in_valid_i / in_ready_o with in_req_i (cmd, byte_count_req, write_word).
// Output channel: out_valid_o / out_ready_i with out_resp_o (resp_kind, bytes_done,
// read_word); every request gives exactly one response, in request order.
// Throughput: one request per cycle while the output does not stall. The position and
// length update is a single add and compare at the input, so requests follow each other
// without gaps. From the input transfer a response passes the middle stage, which holds
// the registered RAM read, and then the output register.
// A read returns the word at the current position; it sees a write made by the
// request just before it. Writes past the last word are dropped, reads there give 0.
// Stall: while out_ready_i is low the response holds and one more request may
// complete into the middle stage; after that in_ready_o drops until the output drains.
// Reset clears the position, the file length and both pipeline stages. The RAM
// keeps no reset value; reading a word never written returns whatever it holds.
module ram_backed_file_store #(
  parameter int unsigned WordBytes  = rbfs_pkg::WORD_BYTES,
  parameter int unsigned StoreBytes = rbfs_pkg::STORE_BYTES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rbfs_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rbfs_pkg::resp_t out_resp_o
);
  import rbfs_pkg::*;

  localparam int unsigned Depth = StoreBytes / WordBytes;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic              s1_valid;
  logic              s1_take;
  s1_info_t          s1_info;
  mem_ctl_t          mem_ctl;
  logic [AddrW-1:0]  mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;

  logic  out_valid_q, out_valid_d;
  resp_t out_resp_q, out_resp_d;

  rbfs_ctrl #(
    .WordBytes (WordBytes),
    .StoreBytes(StoreBytes),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .s1_valid_o (s1_valid),
    .s1_take_i  (s1_take),
    .s1_info_o  (s1_info),
    .mem_ctl_o  (mem_ctl),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata)
  );

  rbfs_ram #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i    (clk_i),
    .mem_ctl_i(mem_ctl),
    .addr_i   (mem_addr),
    .wdata_i  (mem_wdata),
    .rdata_o  (mem_rdata)
  );

  // Advance the middle stage whenever the output register is free or draining
  assign s1_take = s1_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_resp_d  = out_resp_q;
    if (s1_take) begin
      out_valid_d           = 1'b1;
      out_resp_d.resp_kind  = s1_info.kind;
      out_resp_d.bytes_done = s1_info.done;
      out_resp_d.read_word  = s1_info.rd ? mem_rdata : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_resp_q <= out_resp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_resp_o  = out_resp_q;

  a_stall_needs_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !s1_take |-> out_valid_q && !out_ready_i)
    else $error("middle stage held while output could take it");

  a_take_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_take |=> out_valid_q)
    else $error("transfer into output register lost");

  a_no_read_data_off_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_take && s1_info.kind != CMD_READ |=> out_resp_q.read_word == '0)
    else $error("read data on a non-read response");

endmodule
